@@ sv/binary_to_packed_bcd_bytes_core_assert.svh @@
// assertion macros for the binary to packed bcd converter
`ifndef BINARY_TO_PACKED_BCD_BYTES_CORE_ASSERT_SVH
`define BINARY_TO_PACKED_BCD_BYTES_CORE_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define B2PB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define B2PB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/b2pb_pkg.sv @@
// shared types, constants and functions for the binary to packed bcd converter
`default_nettype none

package b2pb_pkg;

   localparam int BIN_W         = 54;
   localparam int CNT_W         = 4;
   localparam int MAX_OUT       = 8;
   localparam int BCD_W         = MAX_OUT * 8;
   localparam int DIGITS        = MAX_OUT * 2;
   localparam int BCD_BYTES_DEF = 8;
   localparam int STAGE_BITS    = 6;
   localparam int NUM_STAGES    = BIN_W / STAGE_BITS;

   typedef struct packed {
      logic [BIN_W-1:0] bin_value;
      logic [CNT_W-1:0] out_bytes;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] bcd_byte;
      logic       last_byte;
      logic       too_large;
   } rsp_payload_type;

   // one item in flight through the conversion pipeline
   typedef struct packed {
      logic [BCD_W-1:0] bcd;
      logic [BIN_W-1:0] bin;
      logic [CNT_W-1:0] cnt;
      logic             err;
   } stage_type;

   // 100 to the power nbytes, only evaluated at elaboration
   function automatic logic [63:0] bcd_limit(input int nbytes);
      logic [63:0] lim;
      lim = 64'd1;
      for (int k = 0; k < nbytes; k++) begin
         lim = lim * 64'd100;
      end
      return lim;
   endfunction

   // one double-dabble step: correct digits of five or more, then shift a bit in
   function automatic logic [BCD_W-1:0] dabble_shift(input logic [BCD_W-1:0] bcd,
                                                     input logic             b);
      logic [BCD_W-1:0] adj;
      adj = bcd;
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd[d*4 +: 4] >= 4'd5) begin
            adj[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
         end
      end
      return {adj[BCD_W-2:0], b};
   endfunction

endpackage

`default_nettype wire

@@ sv/b2pb_dabble_stage.sv @@
// one pipeline stage of the double-dabble conversion, several bits per stage
`default_nettype none

module b2pb_dabble_stage
   import b2pb_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_vld,
   input  wire stage_type in_data,
   output logic           in_rdy,
   output logic           out_vld,
   output stage_type      out_data,
   input  wire logic      out_rdy
);

   logic      vld_ff;
   stage_type data_ff;
   stage_type data_in;

   assign in_rdy   = !vld_ff || out_rdy;
   assign out_vld  = vld_ff;
   assign out_data = data_ff;

   always_comb begin
      data_in = in_data;
      for (int s = 0; s < STAGE_BITS; s++) begin
         data_in.bcd = dabble_shift(data_in.bcd, data_in.bin[BIN_W-1]);
         data_in.bin = {data_in.bin[BIN_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_rdy) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (in_rdy) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/b2pb_serializer.sv @@
// holds one converted item and sends its bytes out one per cycle while rsp_stall is low
`default_nettype none

module b2pb_serializer
   import b2pb_pkg::*;
#(
   parameter int BCD_BYTES = BCD_BYTES_DEF
)
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_vld,
   input  wire stage_type in_data,
   output logic           in_rdy,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic             err_ff, err_in;
   logic [BCD_W-1:0] keep;
   logic [2:0]       idx;
   logic             last;
   logic             xfer;

   // bytes above the configured width are padding
   always_comb begin
      for (int k = 0; k < MAX_OUT; k++) begin
         keep[k*8 +: 8] = (k < BCD_BYTES) ? 8'hFF : 8'h00;
      end
   end

   assign last   = (rem_ff == CNT_W'(1));
   assign xfer   = busy_ff && !rsp_stall;
   assign in_rdy = !busy_ff || (xfer && last);
   assign idx    = 3'(rem_ff - CNT_W'(1));

   always_comb begin
      busy_in = busy_ff;
      rem_in  = rem_ff;
      bcd_in  = bcd_ff;
      err_in  = err_ff;
      if (in_rdy) begin
         busy_in = in_vld;
         rem_in  = in_data.cnt;
         bcd_in  = in_data.err ? '0 : (in_data.bcd & keep);
         err_in  = in_data.err;
      end else if (xfer) begin
         rem_in = rem_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      bcd_ff <= bcd_in;
      err_ff <= err_in;
   end

   assign rsp_valid             = busy_ff;
   assign rsp_payload.bcd_byte  = bcd_ff[idx*8 +: 8];
   assign rsp_payload.last_byte = last;
   assign rsp_payload.too_large = err_ff;

endmodule

`default_nettype wire

@@ sv/binary_to_packed_bcd_bytes_core.sv @@
// top level of the binary to packed bcd converter
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   bin_value, out_bytes
//   rsp      out        rsp_valid/rsp_stall   bcd_byte, last_byte, too_large
//
// an entry register, nine double-dabble stages of six bits each and a byte
// serialiser, passed by each item in that order
// the serialiser sends one byte a cycle while rsp_stall is low; an item gives
// out_bytes bytes (up to eight), or one when too large; a zero count is dropped
// at entry unless too large; synchronous reset clears the valid bits only
// a stall on rsp backs up stage by stage through the pipeline to req_stall
`default_nettype none

module binary_to_packed_bcd_bytes_core
   import b2pb_pkg::*;
#(
   parameter int BCD_BYTES = BCD_BYTES_DEF
)
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload
);

   localparam logic [63:0] LIMIT = bcd_limit(BCD_BYTES);

   logic      ent_vld_ff, ent_vld_in;
   stage_type ent_ff, ent_in;
   logic      ent_rdy;
   logic      too_big;

   logic      stg_vld [NUM_STAGES+1];
   stage_type stg_data[NUM_STAGES+1];
   logic      stg_rdy [NUM_STAGES+1];

   assign too_big = ({(64 - BIN_W)'(0), req_payload.bin_value} >= LIMIT);

   always_comb begin
      ent_in.bcd = '0;
      ent_in.bin = req_payload.bin_value;
      ent_in.err = too_big;
      if (too_big) begin
         ent_in.cnt = CNT_W'(1);
      end else if (req_payload.out_bytes > CNT_W'(MAX_OUT)) begin
         ent_in.cnt = CNT_W'(MAX_OUT);
      end else begin
         ent_in.cnt = req_payload.out_bytes;
      end
      // a zero count makes no bytes at all, unless the value is too large
      ent_vld_in = req_valid && (too_big || (req_payload.out_bytes != '0));
   end

   assign ent_rdy   = !ent_vld_ff || stg_rdy[0];
   assign req_stall = !ent_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= 1'b0;
      end else if (ent_rdy) begin
         ent_vld_ff <= ent_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ent_rdy) begin
         ent_ff <= ent_in;
      end
   end

   assign stg_vld[0]  = ent_vld_ff;
   assign stg_data[0] = ent_ff;

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
      b2pb_dabble_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .in_vld   (stg_vld[i]),
         .in_data  (stg_data[i]),
         .in_rdy   (stg_rdy[i]),
         .out_vld  (stg_vld[i+1]),
         .out_data (stg_data[i+1]),
         .out_rdy  (stg_rdy[i+1])
      );
   end

   b2pb_serializer #(
      .BCD_BYTES (BCD_BYTES)
   ) u_ser (
      .clock       (clock),
      .reset       (reset),
      .in_vld      (stg_vld[NUM_STAGES]),
      .in_data     (stg_data[NUM_STAGES]),
      .in_rdy      (stg_rdy[NUM_STAGES]),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`include "binary_to_packed_bcd_bytes_core_assert.svh"

   // an overflow result is a single zero byte
   `B2PB_ASSERT_NOW(a_err_single, rsp_valid && rsp_payload.too_large, rsp_payload.last_byte && (rsp_payload.bcd_byte == 8'h00), "too_large result must be a lone zero byte")

   // both nibbles of every byte are decimal digits
   `B2PB_ASSERT_NOW(a_digits_decimal, rsp_valid, (rsp_payload.bcd_byte[3:0] <= 4'd9) && (rsp_payload.bcd_byte[7:4] <= 4'd9), "bcd byte holds a non-decimal nibble")

   // after a byte that is not the last, the rest of the item follows
   `B2PB_ASSERT_NEXT(a_item_continues, rsp_valid && !rsp_stall && !rsp_payload.last_byte, rsp_valid, "item ended before its last byte")

endmodule

`default_nettype wire

@@ sim/tb_binary_to_packed_bcd_bytes_core.sv @@
// self-checking testbench for the binary to packed bcd converter
`timescale 1ns / 100ps

module tb_binary_to_packed_bcd_bytes_core;
   import b2pb_pkg::*;

   localparam logic [63:0] BCD_CEILING = 64'd10_000_000_000_000_000;
   localparam int          RANDOM_ITEMS = 400;
   localparam int          QUIET_LIMIT  = 3000;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          DRAIN_CYCLES = 40;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   req_payload_type pending_reqs [$];
   rsp_payload_type expected_bytes [$];

   int send_gap = 0;
   int send_calm = 0;
   int recv_wait = 0;
   int recv_calm = 0;
   int hold_left = 0;
   bit pressure_done = 1'b0;
   int quiet_cycles = 0;
   int fail_count = 0;
   int items_accepted = 0;
   int bytes_checked = 0;
   int oversize_count = 0;
   int dropped_count = 0;

   binary_to_packed_bcd_bytes_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // bytes that one value and count should produce, most significant first
   task automatic predict_bcd(input req_payload_type item);
      logic [63:0]     rest;
      logic [63:0]     pair;
      logic [7:0]      pair_bytes [MAX_OUT];
      int              cnt;
      rsp_payload_type exp_rsp;
      rest = 64'(item.bin_value);
      cnt  = int'(item.out_bytes);
      if (rest >= BCD_CEILING) begin
         exp_rsp.bcd_byte  = 8'h00;
         exp_rsp.last_byte = 1'b1;
         exp_rsp.too_large = 1'b1;
         expected_bytes.push_back(exp_rsp);
         oversize_count++;
      end else if (cnt == 0) begin
         dropped_count++;
      end else begin
         if (cnt > MAX_OUT) begin
            cnt = MAX_OUT;
         end
         for (int k = 0; k < MAX_OUT; k++) begin
            pair          = rest % 64'd100;
            rest          = rest / 64'd100;
            pair_bytes[k] = {4'(pair / 64'd10), 4'(pair % 64'd10)};
         end
         for (int j = 0; j < cnt; j++) begin
            exp_rsp.bcd_byte  = pair_bytes[cnt-1-j];
            exp_rsp.last_byte = (j == cnt - 1);
            exp_rsp.too_large = 1'b0;
            expected_bytes.push_back(exp_rsp);
         end
      end
   endtask

   task automatic check_byte(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_bytes.size() == 0) begin
         $display("%0t unexpected result: expected none, got byte %h last %b too_large %b",
                  $time, got.bcd_byte, got.last_byte, got.too_large);
         fail_count++;
      end else begin
         want = expected_bytes.pop_front();
         bytes_checked++;
         if (got.bcd_byte !== want.bcd_byte) begin
            $display("%0t bcd_byte mismatch: expected %h, got %h",
                     $time, want.bcd_byte, got.bcd_byte);
            fail_count++;
         end
         if (got.last_byte !== want.last_byte) begin
            $display("%0t last_byte mismatch: expected %b, got %b",
                     $time, want.last_byte, got.last_byte);
            fail_count++;
         end
         if (got.too_large !== want.too_large) begin
            $display("%0t too_large mismatch: expected %b, got %b",
                     $time, want.too_large, got.too_large);
            fail_count++;
         end
      end
   endtask

   task automatic queue_item(input logic [63:0] value, input int count);
      req_payload_type item;
      item.bin_value = value[BIN_W-1:0];
      item.out_bytes = count[CNT_W-1:0];
      pending_reqs.push_back(item);
   endtask

   function automatic logic [63:0] pick_value();
      int          kind;
      int          digits;
      logic [63:0] ceiling;
      logic [63:0] raw;
      kind = $urandom_range(0, 99);
      raw  = {$urandom, $urandom};
      if (kind < 70) begin
         // spread over all decimal lengths, not just the top few
         digits  = $urandom_range(1, 16);
         ceiling = 64'd1;
         for (int k = 0; k < digits; k++) begin
            ceiling = ceiling * 64'd10;
         end
         return raw % ceiling;
      end else if (kind < 85) begin
         return raw & ((64'd1 << BIN_W) - 64'd1);
      end else if (kind < 95) begin
         return BCD_CEILING - 64'd3 + 64'($urandom_range(0, 5));
      end
      return 64'($urandom_range(0, 200));
   endfunction

   function automatic int pick_count();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
         return $urandom_range(1, 8);
      end else if (kind < 88) begin
         return MAX_OUT;
      end else if (kind < 94) begin
         return 0;
      end
      return $urandom_range(9, 15);
   endfunction

   // sender: a gap drawn per item, with calm stretches of back-to-back items
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_bcd(req_payload);
            items_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_payload <= pending_reqs.pop_front();
               req_valid   <= 1'b1;
               if (send_calm > 0) begin
                  send_calm--;
                  send_gap = 0;
               end else begin
                  if ($urandom_range(0, 15) == 0) begin
                     send_calm = $urandom_range(15, 40);
                  end
                  send_gap = $urandom_range(0, 11);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: a wait drawn per transfer, plus one long hold-off to back the pipe up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_byte(rsp_payload);
            if (recv_calm > 0) begin
               recv_calm--;
               recv_wait = 0;
            end else begin
               if ($urandom_range(0, 15) == 0) begin
                  recv_calm = $urandom_range(20, 60);
               end
               recv_wait = $urandom_range(0, 11);
            end
         end
         if (!pressure_done && bytes_checked >= 200) begin
            pressure_done = 1'b1;
            hold_left     = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      // zero value, full width and padding
      queue_item(64'd0, 1);
      queue_item(64'd0, 8);
      queue_item(64'd5, 8);
      queue_item(64'd99, 1);
      queue_item(64'd100, 1);
      queue_item(BCD_CEILING - 64'd1, 8);
      queue_item(BCD_CEILING - 64'd1, 5);
      queue_item(64'd1234567890123456, 1);
      queue_item(64'd1234567890123456, 2);
      queue_item(64'd1234567890123456, 4);
      queue_item(64'd1234567890123456, 8);
      queue_item(64'd9007199254740992, 8);
      // out of range, whatever the count
      queue_item(BCD_CEILING, 3);
      queue_item((64'd1 << BIN_W) - 64'd1, 0);
      queue_item((64'd1 << BIN_W) - 64'd1, 15);
      // zero count is dropped, counts above eight saturate
      queue_item(64'd12345678, 0);
      queue_item(64'd12345678, 9);
      queue_item(64'd87654321, 15);
      queue_item(64'd7, 0);
      queue_item(64'd7, 1);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         queue_item(pick_value(), pick_count());
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (expected_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items sent, %0d result bytes checked", items_accepted, bytes_checked);
      $display("%0d out-of-range values, %0d zero-count items dropped",
               oversize_count, dropped_count);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/b2pb_pkg.sv
sv/b2pb_dabble_stage.sv
sv/b2pb_serializer.sv
sv/binary_to_packed_bcd_bytes_core.sv
sim/tb_binary_to_packed_bcd_bytes_core.sv
